FILE: hdl/cro_pkg.sv
// ----------------------------------------------------------------------------
// cro_pkg
// Shared types and constants for the read override cheat engine.
// ----------------------------------------------------------------------------
package cro_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W      = 5;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_ENABLE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_SNOOP  = 3'd4;

    localparam logic [7:0] CODE_EXACT   = 8'h01;
    localparam logic [7:0] CODE_RANGE   = 8'h10;
    localparam logic [7:0] CODE_CEQ     = 8'h20;
    localparam logic [7:0] CODE_CLT     = 8'h21;
    localparam logic [7:0] CODE_CGT     = 8'h22;
    localparam logic [7:0] CODE_BANK_LO = 8'h90;
    localparam logic [7:0] CODE_BANK_HI = 8'h97;

    localparam logic [15:0] WRAM_LO = 16'hD000;
    localparam logic [15:0] WRAM_HI = 16'hE000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  slot_index;
        logic [7:0]  entry_code;
        logic [15:0] entry_addr;
        logic [7:0]  entry_byte;
        logic        chain_continues;
        logic        enable_flag;
        logic [15:0] bus_addr;
        logic [7:0]  mem_data;
        logic [2:0]  wram_bank;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       hit;
    } t_out;

    typedef struct packed {
        logic cap;
        logic scan_step;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic div_go;
        logic last_slot;
        logic scan_end;
        logic div_last;
        logic div_hit;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/cheat_read_override.sv
// ----------------------------------------------------------------------------
// cheat_read_override
// Bus-side cheat engine: slot table with chained codes overriding read bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one command beat:
//   clear table, load slot, set chain enable, read access or write snoop.
//   Output channel (o_out_valid / i_out_stall / o_out) returns exactly one
//   beat per command: for a read the override byte (or the memory byte when
//   no code hits) and the hit flag, zero otherwise.
// Sequencing:
//   Clear, load, enable and snoop are applied to the table as they are
//   captured and then go straight to delivery.
//   A read walks the table one slot per cycle starting at slot 0 and stops at
//   the first hit or the last slot; the walk pauses for a bit-serial remainder
//   test at each range code whose base the read address reaches.
//   The walker works one command at a time: the next command is taken only
//   once the last one has been delivered.
// Reset:
//   Synchronous active-low reset empties the table, zeroes all condition
//   shadows and enables, and drops any pending output beat.
// Stall:
//   A finished beat holds in the output register while i_out_stall is high.
//   The engine still takes and works one more command behind it, then waits
//   in its deliver state with o_in_stall high until the register frees.
// ----------------------------------------------------------------------------
module cheat_read_override (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cro_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cro_pkg::t_out o_out
);
    import cro_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: decides when to capture, walk, divide and deliver
    cro_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in.opcode),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // table, walker and output register
    cro_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

FILE: hdl/cro_ctrl.sv
// ----------------------------------------------------------------------------
// cro_ctrl
// Sequencer: capture an item, walk the slot table, run range tests, deliver.
// ----------------------------------------------------------------------------
module cro_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [2:0]    i_opcode,
    input  cro_pkg::t_sts i_sts,
    output cro_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import cro_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = (i_opcode == OP_READ) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end else if (i_sts.div_go) begin
                    n_state = S_DIV;
                end else if (i_sts.last_slot) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = (i_sts.div_hit || i_sts.scan_end) ? S_DONE : S_SCAN;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hdl/cro_dp.sv
// ----------------------------------------------------------------------------
// cro_dp
// Slot table, chain walker, remainder unit and output register.
// ----------------------------------------------------------------------------
module cro_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cro_pkg::t_in  i_in,
    input  logic          i_out_stall,
    input  cro_pkg::t_cmd i_cmd,
    output cro_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output cro_pkg::t_out o_out
);
    import cro_pkg::*;

    logic [7:0]  r_code   [TABLE_SLOTS];
    logic [15:0] r_addr   [TABLE_SLOTS];
    logic [7:0]  r_byte   [TABLE_SLOTS];
    logic        r_en     [TABLE_SLOTS];
    logic        r_link   [TABLE_SLOTS];
    logic [7:0]  r_shadow [TABLE_SLOTS];

    t_in               r_item;
    t_out              r_res;
    logic [SLOT_W-1:0] r_ptr;
    logic              r_prev_link;
    logic              r_active;
    logic              r_range_pend;
    logic              r_scan_end;
    logic [16:0]       r_stride;
    logic [24:0]       r_span;
    logic [15:0]       r_off;
    logic [15:0]       r_offsh;
    logic [15:0]       r_rem;
    logic [3:0]        r_div_cnt;
    logic [7:0]        r_rbyte;

    logic [7:0]  s_code;
    logic [15:0] s_addr;
    logic [7:0]  s_byte;
    logic        s_en;
    logic        s_link;
    logic [7:0]  s_shadow;
    logic        head;
    logic        act;
    logic        last;
    logic        in_wram;
    logic        scan_hit;
    logic        n_active;
    logic        range_set;
    logic        div_go;
    logic [16:0] stride_n;
    logic [16:0] trial;
    logic [15:0] rem_n;
    logic        div_hit;

    // table write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.cap && i_in.opcode == OP_CLEAR)) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_code[i]   <= '0;
                r_addr[i]   <= '0;
                r_byte[i]   <= '0;
                r_en[i]     <= 1'b0;
                r_link[i]   <= 1'b0;
                r_shadow[i] <= '0;
            end
        end else if (i_cmd.cap) begin
            unique case (i_in.opcode)
                OP_LOAD: begin
                    r_code[i_in.slot_index]   <= i_in.entry_code;
                    r_addr[i_in.slot_index]   <= i_in.entry_addr;
                    r_byte[i_in.slot_index]   <= i_in.entry_byte;
                    r_link[i_in.slot_index]   <= i_in.chain_continues;
                    r_shadow[i_in.slot_index] <= '0;
                end
                OP_ENABLE: begin
                    r_en[i_in.slot_index] <= i_in.enable_flag;
                end
                OP_SNOOP: begin
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (r_addr[i] == i_in.bus_addr) begin
                            r_shadow[i] <= i_in.mem_data;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_code   = r_code[r_ptr];
    assign s_addr   = r_addr[r_ptr];
    assign s_byte   = r_byte[r_ptr];
    assign s_en     = r_en[r_ptr];
    assign s_link   = r_link[r_ptr];
    assign s_shadow = r_shadow[r_ptr];
    assign head     = (r_ptr == '0) || !r_prev_link;
    assign act      = head ? s_en : r_active;
    assign last     = (r_ptr == SLOT_W'(TABLE_SLOTS - 1));
    assign in_wram  = (r_item.bus_addr >= WRAM_LO) && (r_item.bus_addr < WRAM_HI);
    assign stride_n = {1'b0, s_addr} + 17'd1;

    // evaluate one slot
    always_comb begin
        scan_hit  = 1'b0;
        n_active  = 1'b0;
        range_set = 1'b0;
        div_go    = 1'b0;
        if (r_range_pend) begin
            div_go = (r_item.bus_addr >= s_addr);
        end else if (act) begin
            case (s_code)
                CODE_EXACT: scan_hit = (s_addr == r_item.bus_addr);
                CODE_RANGE: range_set = s_link && !last;
                CODE_CEQ:   n_active = (s_shadow == s_byte);
                CODE_CLT:   n_active = (s_shadow < s_byte);
                CODE_CGT:   n_active = (s_shadow > s_byte);
                default: begin
                    scan_hit = (s_code >= CODE_BANK_LO) && (s_code <= CODE_BANK_HI)
                            && (s_addr == r_item.bus_addr)
                            && (!in_wram || (r_item.wram_bank == s_code[2:0]));
                end
            endcase
        end
    end

    // restoring remainder step
    assign trial   = {r_rem, r_offsh[15]};
    assign rem_n   = (trial >= r_stride) ? 16'(trial - r_stride) : trial[15:0];
    assign div_hit = (rem_n == '0) && ({9'd0, r_off} < r_span);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item       <= i_in;
            r_ptr        <= '0;
            r_prev_link  <= 1'b0;
            r_active     <= 1'b0;
            r_range_pend <= 1'b0;
            r_scan_end   <= 1'b0;
            r_res.read_data <= (i_in.opcode == OP_READ) ? i_in.mem_data : 8'd0;
            r_res.hit       <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_ptr        <= r_ptr + SLOT_W'(1);
            r_prev_link  <= s_link;
            r_active     <= n_active;
            r_range_pend <= range_set;
            r_scan_end   <= last;
            if (range_set) begin
                r_stride <= stride_n;
                r_span   <= 25'(stride_n) * 25'(s_byte);
            end
            if (div_go) begin
                r_off     <= r_item.bus_addr - s_addr;
                r_offsh   <= r_item.bus_addr - s_addr;
                r_rem     <= '0;
                r_div_cnt <= '0;
                r_rbyte   <= s_byte;
            end
            if (scan_hit) begin
                r_res.read_data <= s_byte;
                r_res.hit       <= 1'b1;
            end
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_n;
            r_offsh   <= {r_offsh[14:0], 1'b0};
            r_div_cnt <= r_div_cnt + 4'd1;
            if (o_sts.div_last && div_hit) begin
                r_res.read_data <= r_rbyte;
                r_res.hit       <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out <= r_res;
        end
    end

    assign o_sts.hit       = scan_hit;
    assign o_sts.div_go    = div_go;
    assign o_sts.last_slot = last;
    assign o_sts.scan_end  = r_scan_end;
    assign o_sts.div_last  = (r_div_cnt == 4'd15);
    assign o_sts.div_hit   = div_hit;
    assign o_sts.out_free  = !o_out_valid || !i_out_stall;

`ifndef SYNTHESIS
    a_hit_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_res.hit |-> r_item.opcode == OP_READ)
        else $error("hit flagged on a non-read beat");
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_item.opcode != OP_READ |-> r_res == '0)
        else $error("non-read beat carries data");
    a_stride_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_stride != '0)
        else $error("range test with zero stride");
    a_scan_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step && !div_go && !scan_hit && !last |=> r_ptr == $past(r_ptr) + SLOT_W'(1))
        else $error("walk pointer skipped a slot");
`endif

endmodule

FILE: verif/cheat_read_override_tb.sv
// ----------------------------------------------------------------------------
// cheat_read_override_tb
// Self-checking bench: directed table of commands, then random chain programs.
// Every beat is predicted by a local copy of the slot table and compared field
// by field against the block's output stream, with random gaps on both sides.
// ----------------------------------------------------------------------------
module cheat_read_override_tb;
    import cro_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    cheat_read_override i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Local copy of the slot table.
    logic [7:0]  tbl_code [TABLE_SLOTS];
    logic [15:0] tbl_addr [TABLE_SLOTS];
    logic [7:0]  tbl_byte [TABLE_SLOTS];
    logic        tbl_en   [TABLE_SLOTS];
    logic        tbl_link [TABLE_SLOTS];
    logic [7:0]  tbl_cond [TABLE_SLOTS];

    t_out pending_beats[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   long_hold = 1'b0;

    // Directed table: opcode, slot, code, addr, byte, link, en, bus, mem, bank.
    t_in  dir_cmd[$];
    logic dir_known[$];
    t_out dir_want[$];

    function automatic void wipe_table();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_code[i] = '0; tbl_addr[i] = '0; tbl_byte[i] = '0;
            tbl_en[i] = 1'b0; tbl_link[i] = 1'b0; tbl_cond[i] = '0;
        end
    endfunction

    // Walk one chain; return 1 and the override byte on a hit.
    function automatic bit walk_chain(int head, logic [15:0] bus, logic [2:0] bank,
                                      output logic [7:0] val);
        int c;
        int nxt;
        logic [7:0] code;
        int unsigned stride, span, off;
        bit pass;
        c = head;
        val = '0;
        while (c >= 0) begin
            code = tbl_code[c];
            nxt = (tbl_link[c] && c + 1 < TABLE_SLOTS) ? c + 1 : -1;
            if (code == CODE_EXACT) begin
                if (tbl_addr[c] == bus) begin
                    val = tbl_byte[c];
                    return 1'b1;
                end
                return 1'b0;
            end else if (code == CODE_RANGE) begin
                if (nxt < 0) return 1'b0;
                if (bus < tbl_addr[nxt]) return 1'b0;
                stride = int'(tbl_addr[c]) + 1;
                span = stride * int'(tbl_byte[c]);
                off = int'(bus) - int'(tbl_addr[nxt]);
                if (off < span && off % stride == 0) begin
                    val = tbl_byte[nxt];
                    return 1'b1;
                end
                return 1'b0;
            end else if (code == CODE_CEQ || code == CODE_CLT || code == CODE_CGT) begin
                pass = (code == CODE_CEQ) ? (tbl_cond[c] == tbl_byte[c]) :
                       (code == CODE_CLT) ? (tbl_cond[c] <  tbl_byte[c]) :
                                            (tbl_cond[c] >  tbl_byte[c]);
                if (!pass) return 1'b0;
                c = nxt;
            end else if (code >= CODE_BANK_LO && code <= CODE_BANK_HI) begin
                if (tbl_addr[c] != bus) return 1'b0;
                if (bus >= WRAM_LO && bus < WRAM_HI) begin
                    if (code - CODE_BANK_LO == bank) begin
                        val = tbl_byte[c];
                        return 1'b1;
                    end
                    return 1'b0;
                end
                val = tbl_byte[c];
                return 1'b1;
            end else begin
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    // Apply one command to the local table and return the beat it should make.
    function automatic t_out apply_command(t_in cmd);
        t_out res;
        logic [7:0] v;
        res = '0;
        case (cmd.opcode)
            OP_CLEAR: begin
                wipe_table();
            end
            OP_LOAD: begin
                tbl_code[cmd.slot_index] = cmd.entry_code;
                tbl_addr[cmd.slot_index] = cmd.entry_addr;
                tbl_byte[cmd.slot_index] = cmd.entry_byte;
                tbl_link[cmd.slot_index] = cmd.chain_continues;
                tbl_cond[cmd.slot_index] = '0;
            end
            OP_ENABLE: begin
                tbl_en[cmd.slot_index] = cmd.enable_flag;
            end
            OP_READ: begin
                res.read_data = cmd.mem_data;
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if ((i == 0 || !tbl_link[i-1]) && tbl_en[i]) begin
                        if (walk_chain(i, cmd.bus_addr, cmd.wram_bank, v)) begin
                            res.read_data = v;
                            res.hit = 1'b1;
                            break;
                        end
                    end
                end
            end
            OP_SNOOP: begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (tbl_addr[i] == cmd.bus_addr) tbl_cond[i] = cmd.mem_data;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Queue the prediction for one accepted beat.
    function automatic void expect_beat(t_out w);
        pending_beats = {pending_beats, w};
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(t_in c, logic known, t_out w);
        dir_cmd   = {dir_cmd, c};
        dir_known = {dir_known, known};
        dir_want  = {dir_want, w};
    endfunction

    // Idle for a random gap, then drive one beat at the falling edge and hold
    // it until accepted; valid stays high when the next beat follows at once.
    task automatic send_beat(t_in cmd);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in <= cmd;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expect_beat(apply_command(cmd));
    endtask

    function automatic t_in mk(logic [2:0] op, logic [4:0] slot, logic [7:0] code,
                               logic [15:0] addr, logic [7:0] byt, logic link,
                               logic en, logic [15:0] bus, logic [7:0] mem,
                               logic [2:0] bank);
        t_in c;
        c.opcode = op; c.slot_index = slot; c.entry_code = code;
        c.entry_addr = addr; c.entry_byte = byt; c.chain_continues = link;
        c.enable_flag = en; c.bus_addr = bus; c.mem_data = mem; c.wram_bank = bank;
        return c;
    endfunction

    function automatic t_in rand_cmd();
        logic [95:0] raw;
        t_in c;
        raw = {$urandom, $urandom, $urandom};
        c = raw[$bits(t_in)-1:0];
        return c;
    endfunction

    // Random chain program: load slots, enable the head, then read and snoop.
    task automatic random_program(ref int sent);
        int head, len, n_acc;
        logic [15:0] hot_addr[$];
        logic [7:0] codes[6];
        t_in c;
        codes = '{CODE_EXACT, CODE_RANGE, CODE_CEQ, CODE_CLT, CODE_CGT, CODE_BANK_LO};
        hot_addr.delete();
        if ($urandom_range(0, 7) == 0) begin
            send_beat(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0)); sent++;
        end
        head = $urandom_range(0, TABLE_SLOTS - 1);
        len = $urandom_range(1, 4);
        for (int k = 0; k < len && head + k < TABLE_SLOTS; k++) begin
            c = rand_cmd();
            c.opcode = OP_LOAD;
            c.slot_index = 5'(head + k);
            c.entry_code = codes[$urandom_range(0, 5)];
            if (c.entry_code == CODE_BANK_LO)
                c.entry_code = 8'(c.entry_code + $urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) c.entry_code = 8'($urandom);
            if ($urandom_range(0, 1)) c.entry_addr = 16'(16'hD000 + $urandom_range(0, 4095));
            if (c.entry_code == CODE_RANGE && $urandom_range(0, 1))
                c.entry_addr = 16'($urandom_range(0, 7));
            c.chain_continues = (k < len - 1) ? ($urandom_range(0, 9) != 0) : 1'($urandom);
            hot_addr = {hot_addr, c.entry_addr};
            send_beat(c); sent++;
        end
        c = rand_cmd();
        c.opcode = OP_ENABLE;
        c.slot_index = 5'(head);
        c.enable_flag = ($urandom_range(0, 5) != 0);
        send_beat(c); sent++;
        n_acc = $urandom_range(3, 10);
        for (int k = 0; k < n_acc; k++) begin
            c = rand_cmd();
            c.opcode = ($urandom_range(0, 3) == 0) ? OP_SNOOP : OP_READ;
            if ($urandom_range(0, 3) != 0)
                c.bus_addr = 16'(hot_addr[$urandom_range(0, hot_addr.size() - 1)]
                             + $urandom_range(0, 2) * $urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0) c = rand_cmd();
            send_beat(c); sent++;
        end
    endtask

    // Output side: random stalls, one long hold-off to back the block up.
    always @(negedge i_clk) begin
        if (long_hold) begin
            i_out_stall <= 1'b1;
        end else if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 30) ||
                           ($urandom_range(0, 199) == 0);
        end
    end

    // Compare every accepted output beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: read_data=%h hit=%b",
                             o_out.read_data, o_out.hit);
            end else begin
                want = pending_beats.pop_front();
                if (want.read_data !== o_out.read_data || want.hit !== o_out.hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp read_data=%h hit=%b, got %h %b",
                                 want.read_data, want.hit, o_out.read_data, o_out.hit);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || long_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int sent;
        int drain;
        t_out w;
        wipe_table();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Read with empty table passes memory through.
        add_row(mk(OP_READ, 0, 0, 16'hFFFF, 8'hA5, 0, 0, 16'hFFFF, 8'hFF, 7), 1,
                '{8'hFF, 1'b0});
        add_row(mk(OP_LOAD, 0, CODE_EXACT, 16'h0000, 8'h5A, 0, 0, 0, 0, 0), 1, '0);
        // Load leaves enable alone: still no hit.
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'h0000, 8'h00, 0), 1, '{8'h00, 1'b0});
        add_row(mk(OP_ENABLE, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1, '0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'h0000, 8'h33, 0), 1, '{8'h5A, 1'b1});
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'h0001, 8'h33, 0), 1, '{8'h33, 1'b0});
        // Range chain at slots 30/31: stride 4, count 3, base FFF0, byte EE.
        add_row(mk(OP_LOAD, 30, CODE_RANGE, 16'h0003, 8'h03, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(OP_LOAD, 31, CODE_EXACT, 16'hFFF0, 8'hEE, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(OP_ENABLE, 30, 0, 0, 0, 0, 1, 0, 0, 0), 0, '0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'hFFF8, 8'h01, 0), 0, '0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'hFFFC, 8'h01, 0), 0, '0);
        // Condition chain at slots 4..5: shadow of 1234 must equal 77.
        add_row(mk(OP_LOAD, 4, CODE_CEQ, 16'h1234, 8'h77, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(OP_LOAD, 5, CODE_BANK_LO + 8'd3, 16'hD100, 8'h99, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(OP_ENABLE, 4, 0, 0, 0, 0, 1, 0, 0, 0), 0, '0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'hD100, 8'h11, 3), 0, '0);
        add_row(mk(OP_SNOOP, 0, 0, 0, 0, 0, 0, 16'h1234, 8'h77, 0), 1, '0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'hD100, 8'h11, 3), 0, '0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'hD100, 8'h11, 2), 0, '0);
        // Less-than and greater-than tests, plus an unknown code ending a chain.
        add_row(mk(OP_LOAD, 8, CODE_CLT, 16'h4000, 8'h01, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(OP_LOAD, 9, CODE_CGT, 16'h4001, 8'h00, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(OP_LOAD, 10, 8'hFF, 16'h8000, 8'hC3, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(OP_ENABLE, 8, 0, 0, 0, 0, 1, 0, 0, 0), 0, '0);
        add_row(mk(OP_SNOOP, 0, 0, 0, 0, 0, 0, 16'h4001, 8'h80, 0), 0, '0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 16'h8000, 8'h42, 0), 0, '0);
        add_row(mk(3'd7, 31, 8'hFF, 16'hFFFF, 8'hFF, 1, 1, 16'hFFFF, 8'hFF, 7), 1, '0);
        add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0);

        sent = 0;
        foreach (dir_cmd[i]) begin
            send_beat(dir_cmd[i]);
            sent++;
            // Typed-in rows must agree with the prediction just queued.
            w = pending_beats[pending_beats.size() - 1];
            if (dir_known[i] && w !== dir_want[i]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: typed %h, predicted %h", i, dir_want[i], w);
            end
        end

        // Hold the output off while commands keep coming, so the input stalls.
        fork
            begin
                @(negedge i_clk);
                long_hold = 1'b1;
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end
            random_program(sent);
        join

        while (sent < 1450) random_program(sent);

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        drain = 0;
        while (pending_beats.size() != 0 && drain < WATCHDOG) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
